FILE: src/nawd_pkg.sv
package nawd_pkg;

  localparam int unsigned ID_W       = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned TIMER_W    = 32;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_ARM    = 2'd1;
  localparam logic [OP_W-1:0] OP_DISARM = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_ENABLED       = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

  // command into the owner stack, qualified by accept and enable
  typedef struct packed {
    logic            arm;
    logic            disarm;
    logic [ID_W-1:0] id;
  } stk_cmd_t;

  // stack outcome of the current word
  typedef struct packed {
    logic            err;
    logic            was_empty;
    logic            now_empty;
    logic [ID_W-1:0] top_nxt;
  } stk_res_t;

  // timer controls for the current word
  typedef struct packed {
    logic tick;
    logic start;
    logic stop;
    logic busy;
  } tmr_ctl_t;

endpackage

FILE: src/nawd_ram.sv
module nawd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/nawd_stack.sv
module nawd_stack
  import nawd_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 8,
  parameter int unsigned LW          = $clog2(STACK_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  stk_cmd_t      cmd,
  output stk_res_t      res,
  output logic [LW-1:0] level_nxt
);

  // entries below the top live in the ram, the top lives in a register
  localparam int unsigned RAM_D = (STACK_DEPTH > 1) ? STACK_DEPTH - 1 : 1;
  localparam int unsigned AW    = (RAM_D > 1) ? $clog2(RAM_D) : 1;

  logic [LW-1:0]   level_r;
  logic [ID_W-1:0] top_r, top_nxt;
  logic            fwd_r;
  logic [ID_W-1:0] fwd_data_r;
  logic [ID_W-1:0] ram_rdata, below;
  logic            ram_we;
  logic [LW-1:0]   lvl_m1, lvl_nxt_m2;
  logic            empty, full, match, err;

  assign empty      = (level_r == '0);
  assign full       = (level_r == LW'(STACK_DEPTH));
  assign below      = fwd_r ? fwd_data_r : ram_rdata;
  assign match      = !empty && (top_r == cmd.id);
  assign lvl_m1     = level_r - LW'(1);
  assign lvl_nxt_m2 = level_nxt - LW'(2);
  assign ram_we     = cmd.arm && !empty && !full;

  always_comb begin
    level_nxt = level_r;
    top_nxt   = top_r;
    err       = 1'b0;
    if (cmd.arm) begin
      top_nxt = cmd.id;
      if (!full) begin
        level_nxt = level_r + LW'(1);
      end
    end else if (cmd.disarm) begin
      if (match) begin
        level_nxt = lvl_m1;
        top_nxt   = below;
      end else begin
        err       = 1'b1;
        level_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      fwd_r   <= 1'b0;
    end else begin
      level_r <= level_nxt;
      fwd_r   <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    fwd_data_r <= top_r;
  end

  nawd_ram #(
    .WIDTH (ID_W),
    .DEPTH (RAM_D)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lvl_m1[AW-1:0]),
    .wdata (top_r),
    .raddr (lvl_nxt_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign res.err       = err;
  assign res.was_empty = empty;
  assign res.now_empty = (level_nxt == '0);
  assign res.top_nxt   = top_nxt;

endmodule

FILE: src/nawd_timer.sv
module nawd_timer
  import nawd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  tmr_ctl_t           ctl,
  input  logic [TIMER_W-1:0] timeout_ticks,
  output logic               fault
);

  logic               running_r, running_nxt;
  logic [TIMER_W-1:0] elapsed_r, elapsed_nxt, elapsed_inc, limit;

  assign limit       = (timeout_ticks == '0) ? TIMER_W'(1) : timeout_ticks;
  assign elapsed_inc = elapsed_r + TIMER_W'(1);

  always_comb begin
    running_nxt = running_r;
    elapsed_nxt = elapsed_r;
    fault       = 1'b0;
    if (ctl.tick && running_r) begin
      elapsed_nxt = elapsed_inc;
      if (elapsed_inc >= limit) begin
        running_nxt = 1'b0;
        fault       = ctl.busy;
      end
    end else if (ctl.start) begin
      elapsed_nxt = '0;
      running_nxt = 1'b1;
    end else if (ctl.stop) begin
      running_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      elapsed_r <= '0;
    end else begin
      running_r <= running_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

FILE: src/nested_arm_watchdog.sv
// channel  direction  word fields (lsb first)
// in_      slave      opcode[1:0] owner_id[9:2]
// out_     master     timeout_fault stack_error armed stack_level[6:3] active_owner active_valid
// cfg_     write      0 enabled, 1 timeout_ticks
//
// one word per cycle while in_tready is high; each word gives one result word, registered in the cycle after it
// stack below the top sits in a one-port-write ram, read ahead through its registered port at next level-2
// a write followed by a pop of the same entry is served from a forward register
// in_tready drops only while a result waits and out_tready is low
// synchronous active-low reset clears level, timer, enable and output valid and sets timeout_ticks to 1
module nested_arm_watchdog
  import nawd_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // opcode, owner_id
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // timeout_fault, stack_error, armed,
                                            // stack_level, active_owner, active_valid
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

  logic                  enabled_r;
  logic [TIMER_W-1:0]    timeout_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  accept, go;
  logic [OP_W-1:0]       opcode;
  logic [ID_W-1:0]       owner_id;
  stk_cmd_t              cmd;
  stk_res_t              res;
  tmr_ctl_t              tctl;
  logic [LW-1:0]         level_nxt;
  logic [LW+3:0]         level_ext;
  logic                  fault, nonempty;

  assign opcode   = in_tdata[OP_W-1:0];
  assign owner_id = in_tdata[OP_W+ID_W-1:OP_W];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign go        = accept && enabled_r;

  assign cmd.arm    = go && (opcode == OP_ARM);
  assign cmd.disarm = go && (opcode == OP_DISARM);
  assign cmd.id     = owner_id;

  assign tctl.tick  = go && (opcode == OP_TICK);
  assign tctl.start = cmd.arm && res.was_empty;
  assign tctl.stop  = cmd.disarm && res.now_empty;
  assign tctl.busy  = !res.was_empty;

  nawd_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .res       (res),
    .level_nxt (level_nxt)
  );

  nawd_timer u_timer (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (tctl),
    .timeout_ticks (timeout_r),
    .fault         (fault)
  );

  assign nonempty  = !res.now_empty;
  assign level_ext = {4'b0, level_nxt};

  assign out_data_nxt = {nonempty,
                         nonempty ? res.top_nxt : {ID_W{1'b0}},
                         level_ext[3:0],
                         enabled_r && nonempty,
                         res.err,
                         fault};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      timeout_r   <= TIMER_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_ENABLED:       enabled_r <= cfg_wdata[0];
          REG_TIMEOUT_TICKS: timeout_r <= cfg_wdata[TIMER_W-1:0];
          default:           ;
        endcase
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: test/tb.sv
module tb;
  import nawd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 8;
  localparam int WORDS_PER_PHASE = 235;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int PRINT_CAP = 50;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  // laid out as out_tdata, lsb last
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] owner;
    logic [3:0]      lvl;
    logic            armed;
    logic            err;
    logic            fault;
  } status_t;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    bit              on_top;
    bit              typed;
    status_t         want;
  } word_plan_t;

  typedef enum bit {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
    logic [OP_W-1:0]       op;
    logic [ID_W-1:0]       id;
    bit                    typed;
    logic                  fault;
    logic                  err;
    logic                  armed;
    logic [3:0]            lvl;
    logic [ID_W-1:0]       owner;
    logic                  valid;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  nested_arm_watchdog #(.STACK_DEPTH(SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // watchdog copy
  bit              en_reg = 1'b0;
  logic [31:0]     tmo_reg = 32'd1;
  logic [ID_W-1:0] owners [SLOTS];
  int              depth = 0;
  logic [31:0]     elapsed_ticks = '0;
  bit              timer_on = 1'b0;

  word_plan_t word_plan [$];
  status_t    status_due [$];
  word_plan_t cur;
  bit         offering = 1'b0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_req = 1'b0;
  int         hold_count = 0;
  int         quiet_cycles = 0;
  int         n_mismatch = 0;

  // kind, addr, wdata, op, id, typed, fault, err, armed, lvl, owner, valid
  row_t directed_rows [30] = '{
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_TICK, 8'h00, 1, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_ARM, 8'hff, 1, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_CFG, REG_ENABLED, 32'd1, OP_TICK, 8'h00, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_CFG, REG_TIMEOUT_TICKS, 32'd0, OP_TICK, 8'h00, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_DISARM, 8'h00, 1, 0, 1, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_ARM, 8'hff, 1, 0, 0, 1, 4'd1, 8'hff, 1},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_TICK, 8'h00, 1, 1, 0, 1, 4'd1, 8'hff, 1},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_ARM, 8'h00, 1, 0, 0, 1, 4'd2, 8'h00, 1},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_TICK, 8'h00, 1, 0, 0, 1, 4'd2, 8'h00, 1},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_NONE, 8'haa, 1, 0, 0, 1, 4'd2, 8'h00, 1},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_DISARM, 8'h00, 1, 0, 0, 1, 4'd1, 8'hff, 1},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_DISARM, 8'h55, 1, 0, 1, 0, 4'd0, 8'h00, 0},
    '{ROW_CFG, REG_TIMEOUT_TICKS, 32'hffff_ffff, OP_TICK, 8'h00, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_ARM, 8'h01, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_ARM, 8'h02, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_ARM, 8'h04, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_ARM, 8'h08, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_ARM, 8'h10, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_ARM, 8'h20, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_ARM, 8'h40, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_ARM, 8'h80, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_ARM, 8'h3c, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_TICK, 8'h00, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_TICK, 8'h00, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_CFG, REG_TIMEOUT_TICKS, 32'd1, OP_TICK, 8'h00, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_TICK, 8'h00, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_DISARM, 8'h3c, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_CFG, REG_ENABLED, 32'd0, OP_TICK, 8'h00, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_WORD, REG_ENABLED, 32'd0, OP_DISARM, 8'h12, 0, 0, 0, 0, 4'd0, 8'h00, 0},
    '{ROW_CFG, REG_ENABLED, 32'd1, OP_TICK, 8'h00, 0, 0, 0, 0, 4'd0, 8'h00, 0}
  };

  function automatic status_t advance_watchdog(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
    status_t     s;
    logic [31:0] lim;
    s = '0;
    lim = (tmo_reg == 32'd0) ? 32'd1 : tmo_reg;
    if (en_reg) begin
      case (op)
        OP_TICK: begin
          if (timer_on) begin
            elapsed_ticks = elapsed_ticks + 32'd1;
            if (elapsed_ticks >= lim) begin
              timer_on = 1'b0;
              s.fault = (depth > 0);
            end
          end
        end
        OP_ARM: begin
          if (depth == 0) begin
            elapsed_ticks = '0;
            timer_on = 1'b1;
          end
          if (depth < SLOTS) begin
            owners[depth] = id;
            depth = depth + 1;
          end else begin
            owners[SLOTS-1] = id;
          end
        end
        OP_DISARM: begin
          if (depth > 0 && owners[depth-1] == id) begin
            depth = depth - 1;
          end else begin
            s.err = 1'b1;
            depth = 0;
          end
          if (depth == 0) timer_on = 1'b0;
        end
        default: ;
      endcase
    end
    s.armed = en_reg && depth > 0;
    s.lvl = depth[3:0];
    s.valid = depth > 0;
    s.owner = (depth > 0) ? owners[depth-1] : '0;
    return s;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    if (n_mismatch < PRINT_CAP)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    n_mismatch++;
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    if (addr == REG_ENABLED) en_reg = data[0];
    else tmo_reg = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (word_plan.size() != 0 || offering || status_due.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic plan_random(int count);
    word_plan_t w;
    int         r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      w.id = ID_W'($urandom_range(255));
      w.on_top = 1'b0;
      w.typed = 1'b0;
      w.want = '0;
      if (r < 38) w.op = OP_TICK;
      else if (r < 68) w.op = OP_ARM;
      else if (r < 92) begin
        w.op = OP_DISARM;
        w.on_top = 1'b1;
      end else if (r < 96) w.op = OP_DISARM;
      else w.op = OP_NONE;
      word_plan.push_back(w);
    end
  endtask

  // result check, prediction and input drive share one process
  always @(posedge clk) begin : drive_and_check
    status_t got, want;
    if (out_tvalid === 1'b1 && out_tready) begin
      got = status_t'(out_tdata);
      if (status_due.size() == 0) begin
        report("unexpected word", 32'(out_tdata), 0);
      end else begin
        want = status_due.pop_front();
        if (got.fault !== want.fault)
          report("timeout_fault", 32'(got.fault), 32'(want.fault));
        if (got.err !== want.err)
          report("stack_error", 32'(got.err), 32'(want.err));
        if (got.armed !== want.armed)
          report("armed", 32'(got.armed), 32'(want.armed));
        if (got.lvl !== want.lvl)
          report("stack_level", 32'(got.lvl), 32'(want.lvl));
        if (got.owner !== want.owner)
          report("active_owner", 32'(got.owner), 32'(want.owner));
        if (got.valid !== want.valid)
          report("active_valid", 32'(got.valid), 32'(want.valid));
      end
    end
    if (offering && in_tready === 1'b1) begin
      want = advance_watchdog(cur.op, cur.id);
      status_due.push_back(cur.typed ? cur.want : want);
      offering = 1'b0;
    end
    if (!offering && word_plan.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      cur = word_plan.pop_front();
      if (cur.on_top && depth > 0) cur.id = owners[depth-1];
      in_tdata <= IN_DATA_W'({cur.id, cur.op});
      in_tvalid <= 1'b1;
      offering = 1'b1;
    end else if (!offering) begin
      in_tvalid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      out_tready <= 1'b0;
      hold_count++;
      if (hold_count == HOLD_CYCLES) begin
        hold_req = 1'b0;
        hold_count = 0;
      end
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("nested_arm_watchdog regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    word_plan_t w;
    int         r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_quiet();
        write_reg(directed_rows[i].addr, directed_rows[i].wdata);
      end else begin
        w.op = directed_rows[i].op;
        w.id = directed_rows[i].id;
        w.on_top = 1'b0;
        w.typed = directed_rows[i].typed;
        w.want = '{valid: directed_rows[i].valid, owner: directed_rows[i].owner,
                   lvl: directed_rows[i].lvl, armed: directed_rows[i].armed,
                   err: directed_rows[i].err, fault: directed_rows[i].fault};
        word_plan.push_back(w);
      end
    end

    for (int p = 0; p < 8; p++) begin
      wait_quiet();
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 58; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 58; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      write_reg(REG_ENABLED, CFG_DATA_W'($urandom_range(99) < 88));
      r = $urandom_range(9);
      if (r == 0) write_reg(REG_TIMEOUT_TICKS, '0);
      else if (r == 1) write_reg(REG_TIMEOUT_TICKS, 32'hffff_ffff);
      else if (r == 2) write_reg(REG_TIMEOUT_TICKS, $urandom_range(300, 50));
      else write_reg(REG_TIMEOUT_TICKS, $urandom_range(12, 1));
      if (p == 5) begin
        plan_random(WORDS_PER_PHASE / 2);
        // sender holds back until every result is back
        wait_quiet();
        plan_random(WORDS_PER_PHASE - WORDS_PER_PHASE / 2);
      end else begin
        plan_random(WORDS_PER_PHASE);
        // long receiver hold while the sender keeps offering
        if (p == 0) hold_req = 1'b1;
      end
    end

    wait_quiet();
    repeat (4) @(posedge clk);
    if (status_due.size() != 0) report("words never returned", 32'(status_due.size()), 0);
    if (n_mismatch == 0) begin
      $display("nested_arm_watchdog regression: pass");
    end else begin
      $display("nested_arm_watchdog regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/nawd_pkg.sv
src/nawd_ram.sv
src/nawd_stack.sv
src/nawd_timer.sv
src/nested_arm_watchdog.sv
test/tb.sv
